### src/b64e_pkg.sv
`default_nettype none

package b64e_pkg;

  // position within a three-byte group
  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } phase_t;

  localparam logic [6:0] PAD_CHAR = 7'd61;

  localparam int unsigned MAX_CHARS = 4;
  localparam int unsigned IDX_W     = $clog2(MAX_CHARS);

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(Q_DEPTH + 1);

  // characters produced by one input byte
  typedef struct packed {
    logic [MAX_CHARS-1:0][6:0] chars;
    logic [IDX_W-1:0]          last_idx;
    logic                      last;
  } entry_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  // sextet to alphabet character
  function automatic logic [6:0] sym(input logic [5:0] v);
    logic [6:0] v7;
    logic [6:0] ch;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      ch = v7 + 7'd65;
    end else if (v < 6'd52) begin
      ch = v7 + 7'd71;
    end else if (v < 6'd62) begin
      ch = v7 - 7'd4;
    end else if (v == 6'd62) begin
      ch = 7'd43;
    end else begin
      ch = 7'd47;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

### src/b64e_front.sv
`default_nettype none

module b64e_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_last,
  input  wire logic            q_full,
  output logic                 in_ready,
  output logic                 push,
  output b64e_pkg::entry_t     entry
);

  b64e_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]       carry_r, carry_nxt;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    carry_nxt = carry_r;
    if (push) begin
      unique case (phase_r)
        b64e_pkg::PH_1: begin
          phase_nxt = b64e_pkg::PH_2;
          carry_nxt = in_byte[3:0];
        end
        b64e_pkg::PH_2: begin
          phase_nxt = b64e_pkg::PH_0;
          carry_nxt = 4'd0;
        end
        default: begin
          phase_nxt = b64e_pkg::PH_1;
          carry_nxt = {2'b00, in_byte[1:0]};
        end
      endcase
      if (in_last) begin
        phase_nxt = b64e_pkg::PH_0;
        carry_nxt = 4'd0;
      end
    end
  end

  // characters for the current byte
  always_comb begin
    entry          = '0;
    entry.last     = in_last;
    unique case (phase_r)
      b64e_pkg::PH_1: begin
        entry.chars[0] = b64e_pkg::sym({carry_r[1:0], in_byte[7:4]});
        if (in_last) begin
          entry.chars[1] = b64e_pkg::sym({in_byte[3:0], 2'b00});
          entry.chars[2] = b64e_pkg::PAD_CHAR;
          entry.last_idx = b64e_pkg::IDX_W'(2);
        end
      end
      b64e_pkg::PH_2: begin
        entry.chars[0] = b64e_pkg::sym({carry_r, in_byte[7:6]});
        entry.chars[1] = b64e_pkg::sym(in_byte[5:0]);
        entry.last_idx = b64e_pkg::IDX_W'(1);
      end
      default: begin
        entry.chars[0] = b64e_pkg::sym(in_byte[7:2]);
        if (in_last) begin
          entry.chars[1] = b64e_pkg::sym({in_byte[1:0], 4'b0000});
          entry.chars[2] = b64e_pkg::PAD_CHAR;
          entry.chars[3] = b64e_pkg::PAD_CHAR;
          entry.last_idx = b64e_pkg::IDX_W'(3);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= b64e_pkg::PH_0;
      carry_r <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

`default_nettype wire

### src/b64e_queue.sv
`default_nettype none

module b64e_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire b64e_pkg::entry_t     wr_entry,
  input  wire logic                 pop,
  output b64e_pkg::entry_t          head,
  output b64e_pkg::q_status_t       status
);

  b64e_pkg::entry_t                  mem_r [b64e_pkg::Q_DEPTH];
  logic [b64e_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [b64e_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [b64e_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                              do_wr, do_rd;

  localparam logic [b64e_pkg::QPTR_W-1:0] LAST_PTR = b64e_pkg::QPTR_W'(b64e_pkg::Q_DEPTH - 1);
  localparam logic [b64e_pkg::QCNT_W-1:0] FULL_CNT = b64e_pkg::QCNT_W'(b64e_pkg::Q_DEPTH);

  assign status.full  = (count_r == FULL_CNT);
  assign status.empty = (count_r == '0);
  assign status.count = count_r;

  assign do_wr = push && !status.full;
  assign do_rd = pop && !status.empty;

  assign head = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

### src/b64e_back.sv
`default_nettype none

module b64e_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire b64e_pkg::entry_t     head,
  input  wire logic                 q_empty,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [6:0]                out_char,
  output logic                      out_last
);

  logic [b64e_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       valid_r, valid_nxt;
  logic [6:0]                 char_r, char_nxt;
  logic                       last_r, last_nxt;
  logic                       load, at_end;

  // output register takes a new character when empty or being drained
  assign load   = !q_empty && (!valid_r || out_ready);
  assign at_end = (idx_r == head.last_idx);
  assign pop    = load && at_end;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    if (load) begin
      idx_nxt   = at_end ? '0 : idx_r + 1'b1;
      valid_nxt = 1'b1;
      char_nxt  = head.chars[idx_r];
      last_nxt  = head.last && at_end;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_char  = char_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

### src/base64_stream_encoder.sv
// path: an accepted byte is written into the entry queue, and its characters leave through the output register
// throughput: one byte per cycle while the entry queue has room, one character per cycle out while out_tready is high
// sustained: output port bound, four characters per three bytes
// a last byte in the first group position emits four characters, two of them padding
// reset: synchronous active-low rst_n clears group phase, carry bits, queue and output valid
`default_nettype none

module base64_stream_encoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input stream, one raw byte per transaction
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // in_last
  // encoded text stream, one character per transaction
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [6:0] out_char, [7] zero
  output logic            out_tlast   // out_last
);

  // front: group phase tracking, sextet split and alphabet lookup
  b64e_pkg::entry_t    fr_entry;
  logic                fr_push;
  // queue between front and back
  b64e_pkg::entry_t    q_head;
  b64e_pkg::q_status_t q_status;
  // back: serializer into the output register
  logic                bk_pop;
  logic [6:0]          bk_char;

  b64e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .q_full   (q_status.full),
    .in_ready (in_tready),
    .push     (fr_push),
    .entry    (fr_entry)
  );

  b64e_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fr_push),
    .wr_entry (fr_entry),
    .pop      (bk_pop),
    .head     (q_head),
    .status   (q_status)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_status.empty),
    .pop       (bk_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (bk_char),
    .out_last  (out_tlast)
  );

  assign out_tdata = {1'b0, bk_char};

  // queue flags never contradict each other
  a_q_flags : assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty at once");

  // a byte taken in leaves work queued for the back end
  a_push_lands : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !q_status.empty)
    else $error("accepted byte did not reach the queue");

  // fill level stays within the queue depth
  a_q_bound : assert property (@(posedge clk) disable iff (!rst_n)
    q_status.count <= b64e_pkg::QCNT_W'(b64e_pkg::Q_DEPTH))
    else $error("queue fill level beyond depth");

  // the back end only pops when it has something to pop
  a_pop_ok : assert property (@(posedge clk) disable iff (!rst_n)
    bk_pop |-> !q_status.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire
